// ----- rtl/core/segx_pkg.sv -----
// Package: shared types, widths and status codes for the segment intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none
package segx_pkg;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int OUT_WIDTH       = 24;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } status_t;
endpackage
`default_nettype wire

// ----- rtl/core/segment_intersection_top.sv -----
// Top level: segment pair intersection pipeline with stream handshake.
//
// Usage: one segment pair enters per s_axis transfer; one result leaves per
// m_axis transfer, in order. s_tdata packs the eight signed coordinates,
// first_start_x in the lowest bits. m_tdata holds status, cross_x, cross_y.
// The pipeline is 5 front stages, one divider load stage, one divider stage per
// quotient bit (3*COORD_WIDTH+4+FRAC_BITS, 60 at defaults) and the output
// register. Throughput is one pair per cycle while the pipe is not frozen.
// The whole pipeline advances as one; when m_tready is low with a result
// held in the output register, the pipe freezes and s_tready falls, so
// nothing is dropped or repeated. s_tready is high whenever the output
// register is empty or m_tready is high.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not
// cleared. The divider depth is set by the quotient width of the
// fixed-point result.
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_top import segx_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // fields low to high: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  wire logic [8*COORD_WIDTH-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // fields low to high: status(2), cross_x(24), cross_y(24), zero pad(6)
    output logic [55:0]                   m_tdata
);
    localparam int DNW = 2 * COORD_WIDTH + 3;
    localparam int NW  = 3 * COORD_WIDTH + 4;
    localparam int QW  = NW + FRAC_BITS;
    localparam int TW  = 4;

    logic adv;
    logic out_vld_reg;
    logic [55:0] out_data_reg;
    logic signed [COORD_WIDTH-1:0] c [8];

    for (genvar i = 0; i < 8; i++) begin : g_unpack
        assign c[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end

    // pipe moves whenever the output register can take the tail item
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    logic           f_vld, f_xneg, f_yneg;
    status_t        f_st;
    logic [QW-1:0]  f_xm, f_ym;
    logic [DNW-1:0] f_den;

    segx_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk, .aresetn, .adv,
        .in_valid(s_tvalid),
        .x1(c[0]), .y1(c[1]), .x2(c[2]), .y2(c[3]),
        .x3(c[4]), .y3(c[5]), .x4(c[6]), .y4(c[7]),
        .out_valid(f_vld), .out_status(f_st), .out_xneg(f_xneg), .out_yneg(f_yneg),
        .out_xmag(f_xm), .out_ymag(f_ym), .out_den(f_den)
    );

    logic          dx_vld, dy_vld;
    logic [QW-1:0] qx, qy;
    logic [TW-1:0] tx, ty;

    segx_divider #(.NUM_WIDTH(QW), .DEN_WIDTH(DNW), .TAG_WIDTH(TW)) u_divx (
        .aclk, .aresetn, .adv, .in_valid(f_vld), .in_num(f_xm), .in_den(f_den),
        .in_tag({f_xneg, f_yneg, f_st}),
        .out_valid(dx_vld), .out_quo(qx), .out_tag(tx)
    );
    segx_divider #(.NUM_WIDTH(QW), .DEN_WIDTH(DNW), .TAG_WIDTH(TW)) u_divy (
        .aclk, .aresetn, .adv, .in_valid(f_vld), .in_num(f_ym), .in_den(f_den),
        .in_tag({f_xneg, f_yneg, f_st}),
        .out_valid(dy_vld), .out_quo(qy), .out_tag(ty)
    );

    // sign restore and result formatting
    logic [OUT_WIDTH-1:0] rx, ry;
    logic hit;
    always_comb begin
        hit = (status_t'(tx[1:0]) == ST_HIT) && (ty == tx);
        rx  = tx[3] ? OUT_WIDTH'(-qx) : OUT_WIDTH'(qx);
        ry  = tx[2] ? OUT_WIDTH'(-qy) : OUT_WIDTH'(qy);
        if (!hit) begin
            rx = '0;
            ry = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= dx_vld && dy_vld;
        if (adv) out_data_reg <= {6'd0, ry, rx, tx[1:0]};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
endmodule
`default_nettype wire

// ----- rtl/core/segx_divider.sv -----
// Pipelined restoring divider: unsigned quotient, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module segx_divider import segx_pkg::*; #(
    parameter int NUM_WIDTH = 56,
    parameter int DEN_WIDTH = 33,
    parameter int TAG_WIDTH = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [NUM_WIDTH-1:0] in_num,
    input  wire logic [DEN_WIDTH-1:0] in_den,
    input  wire logic [TAG_WIDTH-1:0] in_tag,
    output logic                      out_valid,
    output logic [NUM_WIDTH-1:0]      out_quo,
    output logic [TAG_WIDTH-1:0]      out_tag
);
    localparam int RW = DEN_WIDTH + 1;

    logic [NUM_WIDTH:0]   vld_reg;
    logic [NUM_WIDTH-1:0] num_reg [NUM_WIDTH+1];
    logic [RW-1:0]        rem_reg [NUM_WIDTH+1];
    logic [DEN_WIDTH-1:0] den_reg [NUM_WIDTH+1];
    logic [TAG_WIDTH-1:0] tag_reg [NUM_WIDTH+1];

    // stage 0 loads operands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
        if (adv) begin
            num_reg[0] <= in_num;
            rem_reg[0] <= '0;
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
        end
    end

    // one shift-subtract step per stage, quotient bits shift into num
    for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_step
        logic [RW-1:0] sh;
        logic [RW:0]   diff;
        assign sh   = {rem_reg[i][RW-2:0], num_reg[i][NUM_WIDTH-1]};
        assign diff = {1'b0, sh} - {2'b00, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (adv) begin
                rem_reg[i+1] <= diff[RW] ? sh : diff[RW-1:0];
                num_reg[i+1] <= {num_reg[i][NUM_WIDTH-2:0], ~diff[RW]};
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[NUM_WIDTH];
    assign out_quo   = num_reg[NUM_WIDTH];
    assign out_tag   = tag_reg[NUM_WIDTH];
endmodule
`default_nettype wire

// ----- rtl/core/segx_front.sv -----
// Front pipeline: differences, determinant, numerators, exact bounds check.
`timescale 1ns / 1ps
`default_nettype none
module segx_front import segx_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int DW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * COORD_WIDTH + 1,
    localparam int DNW = 2 * COORD_WIDTH + 3,
    localparam int NW  = 3 * COORD_WIDTH + 4,
    localparam int QW  = NW + FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2, x3, y3, x4, y4,
    output logic                               out_valid,
    output status_t                            out_status,
    output logic                               out_xneg,
    output logic                               out_yneg,
    output logic [QW-1:0]                      out_xmag,
    output logic [QW-1:0]                      out_ymag,
    output logic [DNW-1:0]                     out_den
);
    localparam int MW = NW + DW;

    // stage 1: differences and products
    logic                          v1_reg;
    logic signed [COORD_WIDTH-1:0] c1_reg [8];
    logic signed [DW-1:0]          dx12_reg, dy12_reg, dx34_reg, dy34_reg;
    logic signed [DNW-1:0]         pa_reg, pb_reg, pre_reg, post_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= in_valid;
        if (adv) begin
            c1_reg   <= '{x1, y1, x2, y2, x3, y3, x4, y4};
            dx12_reg <= DW'(x1) - DW'(x2);
            dy12_reg <= DW'(y1) - DW'(y2);
            dx34_reg <= DW'(x3) - DW'(x4);
            dy34_reg <= DW'(y3) - DW'(y4);
            pa_reg   <= DNW'(x1 * y2) - DNW'(y1 * x2);
            pb_reg   <= DNW'(x3 * y4) - DNW'(y3 * x4);
            pre_reg  <= '0;
            post_reg <= '0;
        end
    end

    // stage 2: determinant products and numerator partial products
    logic                  v2_reg;
    logic signed [COORD_WIDTH-1:0] c2_reg [8];
    logic signed [DNW-1:0] da_reg, db_reg;
    logic signed [NW-1:0]  xa_reg, xb_reg, ya_reg, yb_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
        if (adv) begin
            c2_reg <= c1_reg;
            da_reg <= DNW'(dx12_reg * dy34_reg);
            db_reg <= DNW'(dy12_reg * dx34_reg);
            xa_reg <= NW'((pa_reg + pre_reg) * dx34_reg);
            xb_reg <= NW'(dx12_reg * (pb_reg + post_reg));
            ya_reg <= NW'((pa_reg + pre_reg) * dy34_reg);
            yb_reg <= NW'(dy12_reg * (pb_reg + post_reg));
        end
    end

    // stage 3: determinant and numerators, sign normalized so den >= 0
    logic                  v3_reg;
    logic signed [COORD_WIDTH-1:0] c3_reg [8];
    logic signed [DNW-1:0] den3_reg;
    logic signed [NW-1:0]  xn3_reg, yn3_reg;
    logic                  par3_reg;
    logic signed [DNW-1:0] d_c;
    logic signed [NW-1:0]  xn_c, yn_c;
    always_comb begin
        d_c  = da_reg - db_reg;
        xn_c = xa_reg - xb_reg;
        yn_c = ya_reg - yb_reg;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
        if (adv) begin
            c3_reg   <= c2_reg;
            par3_reg <= (d_c == '0);
            den3_reg <= d_c[DNW-1] ? -d_c : d_c;
            xn3_reg  <= d_c[DNW-1] ? -xn_c : xn_c;
            yn3_reg  <= d_c[DNW-1] ? -yn_c : yn_c;
        end
    end

    // stage 4: bound products (coordinate times den)
    logic                  v4_reg, par4_reg;
    logic signed [DNW-1:0] den4_reg;
    logic signed [NW-1:0]  xn4_reg, yn4_reg;
    logic signed [MW-1:0]  bp_reg [8];
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
        if (adv) begin
            par4_reg <= par3_reg;
            den4_reg <= den3_reg;
            xn4_reg  <= xn3_reg;
            yn4_reg  <= yn3_reg;
            for (int k = 0; k < 8; k++) begin
                bp_reg[k] <= MW'(c3_reg[k] * den3_reg);
            end
        end
    end

    // stage 5: compares and status
    function automatic logic inb(input logic signed [MW-1:0] n,
                                 input logic signed [MW-1:0] a,
                                 input logic signed [MW-1:0] b);
        logic signed [MW-1:0] lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (n >= lo) && (n <= hi);
    endfunction

    logic                  v5_reg;
    status_t               st5_reg;
    logic                  xneg_reg, yneg_reg;
    logic [NW-1:0]         xm_reg, ym_reg;
    logic [DNW-1:0]        den5_reg;
    logic                  ok_c;
    logic signed [MW-1:0]  xe, ye;
    always_comb begin
        xe   = MW'(xn4_reg);
        ye   = MW'(yn4_reg);
        ok_c = inb(xe, bp_reg[0], bp_reg[2]) && inb(xe, bp_reg[4], bp_reg[6]) &&
               inb(ye, bp_reg[1], bp_reg[3]) && inb(ye, bp_reg[5], bp_reg[7]);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (adv) v5_reg <= v4_reg;
        if (adv) begin
            st5_reg  <= par4_reg ? ST_PARALLEL : (ok_c ? ST_HIT : ST_OUTSIDE);
            xneg_reg <= xn4_reg[NW-1];
            yneg_reg <= yn4_reg[NW-1];
            xm_reg   <= xn4_reg[NW-1] ? NW'(-xn4_reg) : NW'(xn4_reg);
            ym_reg   <= yn4_reg[NW-1] ? NW'(-yn4_reg) : NW'(yn4_reg);
            den5_reg <= par4_reg ? DNW'(1) : DNW'(den4_reg);
        end
    end

    assign out_valid  = v5_reg;
    assign out_status = st5_reg;
    assign out_xneg   = xneg_reg;
    assign out_yneg   = yneg_reg;
    assign out_xmag   = QW'(xm_reg) << FRAC_BITS;
    assign out_ymag   = QW'(ym_reg) << FRAC_BITS;
    assign out_den    = den5_reg;
endmodule
`default_nettype wire
